FILE: hw/rtl/dns_name_label_encoder_assert.svh
// Assertion macros used by the checker file.
`ifndef DNS_NAME_LABEL_ENCODER_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is asserted.
`define DNLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

FILE: hw/rtl/dnle_pkg.sv
package dnle_pkg;

    localparam int OP_W  = 2;
    localparam int CH_W  = 8;
    localparam int ERR_W = 2;

    // Defaults for the top-level parameters
    localparam int LABEL_MAX_DEF = 63;
    localparam int NAME_MAX_DEF  = 255;

    // Label separator
    localparam logic [CH_W-1:0] DOT_CHAR = 8'h2E;

    // Request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_CHAR  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_ROOT  = 2'd2
    } t_op;

    // Sticky error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_LABEL_LONG = 2'd1,
        ERR_NAME_LONG  = 2'd2,
        ERR_EMPTY      = 2'd3
    } t_err;

    // Encoder sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_FETCH,
        S_LOAD
    } t_state;

endpackage

FILE: hw/rtl/dnle_req_if.sv
// Input channel: one name character or command per request.
interface dnle_req_if;
    logic                        valid;
    logic                        ready;
    logic [dnle_pkg::OP_W-1:0]   op;
    logic [dnle_pkg::CH_W-1:0]   ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

FILE: hw/rtl/dnle_rsp_if.sv
// Output channel: one wire byte per transfer.
interface dnle_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dnle_pkg::CH_W-1:0]   wire_byte;
    logic                        run_last;
    logic [dnle_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output wire_byte, output run_last, output error_code,
                    input ready);
    modport sink   (input valid, input wire_byte, input run_last, input error_code,
                    output ready);
endinterface

FILE: hw/rtl/dns_name_label_encoder.sv
// DNS name label encoder. Feed a dotted name one character per request (op 0);
// characters are held in a LABEL_MAX-entry label memory until a dot or a close
// request (op 1), which sends the label out as a length byte and its characters.
// A root request (op 2) sends the zero terminator, reports the sticky error and
// returns the block to its reset state. Character requests and requests that
// emit nothing are taken back to back. A label flush sends the length byte,
// then each character by a registered read of the label memory and a load
// into the output register; the root request sends only its zero byte. New
// requests are taken only once the previous one has loaded its last byte into
// the output register, which may still wait there while the receiver stalls.
// Errors (sticky, first one kept): 1 label too long, 2 name too long (checked
// including the root byte against NAME_MAX), 3 empty label. Faulty labels are
// dropped, not encoded. No clearing pass is needed after reset.
module dns_name_label_encoder #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int NAME_MAX  = dnle_pkg::NAME_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dnle_req_if.sink        i_req,
    dnle_rsp_if.source      o_rsp
);

    localparam int FW = $clog2(LABEL_MAX + 1);
    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam int TW = $clog2(NAME_MAX + 1);
    localparam int SW = $clog2(NAME_MAX + LABEL_MAX + 3);

    // Control state
    dnle_pkg::t_state r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [TW-1:0]    r_total, n_total;
    dnle_pkg::t_err   r_err, n_err;
    logic             r_after_dot, n_after_dot;
    logic             r_overrun, n_overrun;
    logic             r_ov, n_ov;

    // Payload state
    logic [FW-1:0]              r_len, n_len;
    logic [FW-1:0]              r_idx, n_idx;
    logic [dnle_pkg::CH_W-1:0]  r_head_byte, n_head_byte;
    dnle_pkg::t_err             r_head_err, n_head_err;
    logic                       r_head_last, n_head_last;
    logic [dnle_pkg::CH_W-1:0]  r_ob, n_ob;
    logic                       r_ol, n_ol;
    dnle_pkg::t_err             r_oe, n_oe;

    // Label memory
    logic [dnle_pkg::CH_W-1:0]  r_mem [LABEL_MAX];
    logic [dnle_pkg::CH_W-1:0]  r_rd_data;
    logic                       wr_en;
    logic                       rd_en;

    logic          accept;
    logic          slot_free;
    logic          is_dot;
    logic          fits;
    logic [SW-1:0] need;
    logic [FW-1:0] idx_next;
    dnle_pkg::t_op op_code;

    assign accept    = i_req.valid && i_req.ready;
    assign slot_free = !r_ov || o_rsp.ready;
    assign op_code   = dnle_pkg::t_op'(i_req.op);
    assign is_dot    = (i_req.ch == dnle_pkg::DOT_CHAR);
    assign need      = SW'(r_total) + SW'(r_fill) + SW'(2);
    assign fits      = (need <= SW'(NAME_MAX));
    assign idx_next  = r_idx + FW'(1);

    assign i_req.ready      = (r_state == dnle_pkg::S_IDLE);
    assign o_rsp.valid      = r_ov;
    assign o_rsp.wire_byte  = r_ob;
    assign o_rsp.run_last   = r_ol;
    assign o_rsp.error_code = r_oe;

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_total     = r_total;
        n_err       = r_err;
        n_after_dot = r_after_dot;
        n_overrun   = r_overrun;
        n_len       = r_len;
        n_idx       = r_idx;
        n_head_byte = r_head_byte;
        n_head_err  = r_head_err;
        n_head_last = r_head_last;
        n_ov        = r_ov && !o_rsp.ready;
        n_ob        = r_ob;
        n_ol        = r_ol;
        n_oe        = r_oe;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            dnle_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (op_code) inside
                        dnle_pkg::OP_CHAR, dnle_pkg::OP_CLOSE: begin
                            if (op_code == dnle_pkg::OP_CHAR && !is_dot) begin
                                // buffer a label character
                                n_after_dot = 1'b0;
                                if (!r_overrun) begin
                                    if (r_fill < FW'(LABEL_MAX)) begin
                                        wr_en  = 1'b1;
                                        n_fill = r_fill + FW'(1);
                                    end else begin
                                        n_overrun = 1'b1;
                                        if (r_err == dnle_pkg::ERR_OK)
                                            n_err = dnle_pkg::ERR_LABEL_LONG;
                                    end
                                end
                            end else if (op_code == dnle_pkg::OP_CHAR && r_after_dot) begin
                                // dot with no label in front of it
                                if (r_err == dnle_pkg::ERR_OK)
                                    n_err = dnle_pkg::ERR_EMPTY;
                            end else begin
                                // flush pending label
                                if (!r_overrun && r_fill != '0) begin
                                    if (!fits) begin
                                        if (r_err == dnle_pkg::ERR_OK)
                                            n_err = dnle_pkg::ERR_NAME_LONG;
                                    end else begin
                                        n_head_byte = dnle_pkg::CH_W'(r_fill);
                                        n_head_err  = r_err;
                                        n_head_last = 1'b0;
                                        n_len       = r_fill;
                                        n_total     = TW'(need - SW'(1));
                                        n_state     = dnle_pkg::S_HEAD;
                                    end
                                end
                                n_fill      = '0;
                                n_overrun   = 1'b0;
                                n_after_dot = 1'b1;
                            end
                        end
                        dnle_pkg::OP_ROOT: begin
                            // terminator byte, then back to reset state
                            n_head_byte = '0;
                            n_head_err  = r_err;
                            n_head_last = 1'b1;
                            n_state     = dnle_pkg::S_HEAD;
                            n_fill      = '0;
                            n_total     = '0;
                            n_err       = dnle_pkg::ERR_OK;
                            n_after_dot = 1'b1;
                            n_overrun   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            dnle_pkg::S_HEAD: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_ob    = r_head_byte;
                    n_ol    = r_head_last;
                    n_oe    = r_head_err;
                    n_idx   = '0;
                    n_state = r_head_last ? dnle_pkg::S_IDLE : dnle_pkg::S_FETCH;
                end
            end
            dnle_pkg::S_FETCH: begin
                rd_en   = 1'b1;
                n_state = dnle_pkg::S_LOAD;
            end
            dnle_pkg::S_LOAD: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_ob    = r_rd_data;
                    n_ol    = (idx_next == r_len);
                    n_oe    = r_err;
                    n_idx   = idx_next;
                    n_state = (idx_next == r_len) ? dnle_pkg::S_IDLE : dnle_pkg::S_FETCH;
                end
            end
            default: n_state = dnle_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dnle_pkg::S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_err       <= dnle_pkg::ERR_OK;
            r_after_dot <= 1'b1;
            r_overrun   <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_err       <= n_err;
            r_after_dot <= n_after_dot;
            r_overrun   <= n_overrun;
            r_ov        <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_head_byte <= n_head_byte;
        r_head_err  <= n_head_err;
        r_head_last <= n_head_last;
        r_ob        <= n_ob;
        r_ol        <= n_ol;
        r_oe        <= n_oe;
    end

    // Label memory: write on buffered character, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[r_fill[AW-1:0]] <= i_req.ch;
        if (rd_en)
            r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

endmodule

FILE: hw/rtl/dnle_checker.sv
`include "dns_name_label_encoder_assert.svh"

// Port-level checks for the label encoder.
module dnle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dnle_pkg::CH_W-1:0]   i_out_byte,
    input logic                        i_out_last,
    input logic [dnle_pkg::ERR_W-1:0]  i_out_err
);

    logic                                        stall;
    logic                                        mid_run;
    logic [dnle_pkg::CH_W+dnle_pkg::ERR_W:0]     out_word;

    assign stall    = i_out_valid && !i_out_ready;
    assign mid_run  = i_out_valid && !i_out_last;
    assign out_word = {i_out_byte, i_out_last, i_out_err};

    // Stalled response stays valid and unchanged
    `DNLE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stall, i_out_valid)
    `DNLE_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, stall, $stable(out_word))

    // No new request while the current one still owes bytes
    `DNLE_ASSERT_IMP(a_busy_run, i_clk, i_rst_n, mid_run, !i_in_ready)

    // Error code holds across the bytes of one request
    `DNLE_ASSERT_NXT(a_err_run, i_clk, i_rst_n, mid_run, !i_out_valid || i_out_err == $past(i_out_err))

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_byte  (o_rsp.wire_byte),
    .i_out_last  (o_rsp.run_last),
    .i_out_err   (o_rsp.error_code)
);

FILE: tb/tb_dns_name_label_encoder.sv
// One expected output byte of the encoder.
typedef struct packed {
    logic [dnle_pkg::CH_W-1:0]  wire_byte;
    logic                       run_last;
    logic [dnle_pkg::ERR_W-1:0] error_code;
} t_wire_out;

// Label encoding predictor and byte queue. Notes every accepted request and
// checks every accepted response against the oldest predicted byte.
class label_encoder_scoreboard #(int LMAX = 63, int NMAX = 255);
    // Predictor state for the name in progress
    logic [dnle_pkg::CH_W-1:0] label_chars [LMAX];
    int unsigned               label_len;
    int unsigned               name_bytes;
    dnle_pkg::t_err            first_err;
    bit                        at_label_start;
    bit                        label_overflow;

    logic [dnle_pkg::CH_W-1:0] burst_q[$];
    t_wire_out                 wire_q[$];

    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned requests_noted;
    int unsigned roots_by_err [4];

    function new();
        mismatches     = 0;
        bytes_checked  = 0;
        requests_noted = 0;
        foreach (roots_by_err[i]) roots_by_err[i] = 0;
        clear_name();
    endfunction

    function void clear_name();
        label_len      = 0;
        name_bytes     = 0;
        first_err      = dnle_pkg::ERR_OK;
        at_label_start = 1'b1;
        label_overflow = 1'b0;
    endfunction

    // Only the first error of a name is kept
    function void raise_err(dnle_pkg::t_err code);
        if (first_err == dnle_pkg::ERR_OK) first_err = code;
    endfunction

    // Encode the pending label unless it overflowed or would push the name
    // (root byte included) past NMAX; the label is cleared either way.
    function void flush_label();
        if (!label_overflow && label_len > 0) begin
            if (name_bytes + label_len + 2 > NMAX) begin
                raise_err(dnle_pkg::ERR_NAME_LONG);
            end else begin
                burst_q.push_back(dnle_pkg::CH_W'(label_len));
                for (int i = 0; i < label_len; i++) burst_q.push_back(label_chars[i]);
                name_bytes += label_len + 1;
            end
        end
        label_len      = 0;
        label_overflow = 1'b0;
        at_label_start = 1'b1;
    endfunction

    function void note_request(logic [dnle_pkg::OP_W-1:0] op, logic [dnle_pkg::CH_W-1:0] ch);
        t_wire_out w;
        burst_q.delete();
        requests_noted++;
        case (op)
            dnle_pkg::OP_CHAR: begin
                if (ch == dnle_pkg::DOT_CHAR) begin
                    if (at_label_start) raise_err(dnle_pkg::ERR_EMPTY);
                    else flush_label();
                end else begin
                    at_label_start = 1'b0;
                    // characters past an overflow are dropped silently
                    if (!label_overflow) begin
                        if (label_len < LMAX) begin
                            label_chars[label_len] = ch;
                            label_len++;
                        end else begin
                            label_overflow = 1'b1;
                            raise_err(dnle_pkg::ERR_LABEL_LONG);
                        end
                    end
                end
            end
            dnle_pkg::OP_CLOSE: flush_label();
            dnle_pkg::OP_ROOT:  burst_q.push_back('0);
            default: ;
        endcase
        // error field carries the sticky code after this request
        foreach (burst_q[i]) begin
            w.wire_byte  = burst_q[i];
            w.run_last   = (i == burst_q.size() - 1);
            w.error_code = first_err;
            wire_q.push_back(w);
        end
        if (op == dnle_pkg::OP_ROOT) begin
            roots_by_err[first_err]++;
            clear_name();
        end
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
        $display("MISMATCH byte %0d %s: got %h expected %h", bytes_checked, what, got, want);
        mismatches++;
    endtask

    task check_result(logic [dnle_pkg::CH_W-1:0] wire_byte, logic run_last,
                      logic [dnle_pkg::ERR_W-1:0] error_code);
        t_wire_out want;
        if (wire_q.size() == 0) begin
            report("unexpected response", wire_byte, 'x);
        end else begin
            want = wire_q.pop_front();
            bytes_checked++;
            if (wire_byte !== want.wire_byte) report("wire_byte", wire_byte, want.wire_byte);
            if (run_last !== want.run_last) report("run_last", run_last, want.run_last);
            if (error_code !== want.error_code) report("error_code", error_code, want.error_code);
        end
    endtask

    function int unsigned pending();
        return wire_q.size();
    endfunction
endclass

module tb_dns_name_label_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LABEL_MAX        = dnle_pkg::LABEL_MAX_DEF;
    localparam int NAME_MAX         = dnle_pkg::NAME_MAX_DEF;
    localparam logic [dnle_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS      = 320;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES    = 200;
    localparam int TIMEOUT_NS       = 4_000_000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_SPARSE,
        STALL_TOGGLE
    } t_stall;

    logic i_clk;
    logic i_rst_n;

    dnle_req_if req_ch ();
    dnle_rsp_if rsp_ch ();

    dns_name_label_encoder #(
        .LABEL_MAX (LABEL_MAX),
        .NAME_MAX  (NAME_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    label_encoder_scoreboard #(LABEL_MAX, NAME_MAX) sb;

    int unsigned burst_left;
    int unsigned counted_items;
    int unsigned hold_off_count;
    bit          hold_off_req;

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Response ready: random stall patterns per segment, plus a long hold-off on demand
    initial begin
        t_stall      mode;
        int unsigned seg;
        rsp_ch.ready <= 1'b0;
        hold_off_count = 0;
        forever begin
            mode = t_stall'($urandom_range(0, 3));
            seg  = $urandom_range(8, 64);
            repeat (seg) begin
                if (hold_off_req) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                    hold_off_req = 1'b0;
                    hold_off_count++;
                end
                case (mode)
                    STALL_NONE:   rsp_ch.ready <= 1'b1;
                    STALL_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:      rsp_ch.ready <= !rsp_ch.ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            sb.check_result(rsp_ch.wire_byte, rsp_ch.run_last, rsp_ch.error_code);
        end
    end

    // Issue one request; the sender runs in bursts separated by random gaps
    task automatic send_req(input logic [dnle_pkg::OP_W-1:0] op,
                            input logic [dnle_pkg::CH_W-1:0] ch);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.ch    <= ch;
        do @(posedge i_clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        sb.note_request(op, ch);
        if (op != OP_UNUSED) counted_items++;
        burst_left--;
    endtask

    function automatic logic [dnle_pkg::CH_W-1:0] label_char();
        logic [dnle_pkg::CH_W-1:0] c;
        do c = dnle_pkg::CH_W'($urandom_range(0, 255)); while (c == dnle_pkg::DOT_CHAR);
        return c;
    endfunction

    task automatic send_label(input int unsigned len);
        repeat (len) send_req(dnle_pkg::OP_CHAR, label_char());
    endtask

    // Stop offering requests until every predicted byte has come out
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed names with random content, sprinkled with noise
    task automatic send_name();
        int unsigned labels;
        int unsigned len;
        labels = $urandom_range(1, 5);
        for (int i = 0; i < labels; i++) begin
            case ($urandom_range(0, 15))
                0:       send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);   // empty label
                1:       send_req(OP_UNUSED, dnle_pkg::CH_W'($urandom_range(0, 255)));
                2:       send_req(dnle_pkg::OP_CLOSE,                       // close mid-name
                                  dnle_pkg::CH_W'($urandom_range(0, 255)));
                default: ;
            endcase
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(LABEL_MAX - 3, LABEL_MAX + 3)
                                               : $urandom_range(1, 8);
            send_label(len);
            if (i < labels - 1 || $urandom_range(0, 2) == 0)
                send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        end
        case ($urandom_range(0, 7))
            0: ;  // root drops whatever label is pending
            1: begin
                send_req(dnle_pkg::OP_CLOSE, dnle_pkg::CH_W'($urandom_range(0, 255)));
                send_label($urandom_range(1, 4));
            end
            default: send_req(dnle_pkg::OP_CLOSE, dnle_pkg::CH_W'($urandom_range(0, 255)));
        endcase
        send_req(dnle_pkg::OP_ROOT, dnle_pkg::CH_W'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial begin
        sb = new();
        burst_left    = 0;
        counted_items = 0;
        hold_off_req  = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= dnle_pkg::OP_CHAR;
        req_ch.ch    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bare root, extreme characters, trailing close, unused op,
        // characters after close dropped by root, single dot, double dot
        send_req(dnle_pkg::OP_ROOT, 8'hFF);
        send_req(dnle_pkg::OP_CHAR, 8'h00);
        send_req(dnle_pkg::OP_CHAR, 8'hFF);
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_req(dnle_pkg::OP_CHAR, "a");
        send_req(dnle_pkg::OP_CLOSE, 8'h00);
        send_req(dnle_pkg::OP_CLOSE, 8'hFF);
        send_req(OP_UNUSED, 8'hA5);
        send_req(dnle_pkg::OP_CHAR, "z");
        send_req(dnle_pkg::OP_ROOT, 8'h00);
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_req(dnle_pkg::OP_ROOT, 8'h5A);
        send_req(dnle_pkg::OP_CHAR, "q");
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_req(dnle_pkg::OP_CHAR, "r");
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_req(dnle_pkg::OP_ROOT, 8'h3C);
        wait_drained();

        // Name filled to exactly NAME_MAX, then one more label overflows it;
        // the receiver holds off meanwhile so the output backs up
        hold_off_req = 1'b1;
        repeat (3) begin
            send_label(LABEL_MAX);
            send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        end
        send_label(NAME_MAX - 3 * (LABEL_MAX + 1) - 2);
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_label($urandom_range(1, 3));
        send_req(dnle_pkg::OP_CLOSE, 8'h00);
        send_req(dnle_pkg::OP_ROOT, 8'hFF);

        // Label just past LABEL_MAX inside an otherwise good name
        send_label($urandom_range(1, 4));
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_label(LABEL_MAX + $urandom_range(1, 3));
        send_req(dnle_pkg::OP_CHAR, dnle_pkg::DOT_CHAR);
        send_label($urandom_range(1, 4));
        send_req(dnle_pkg::OP_CLOSE, 8'hFF);
        send_req(dnle_pkg::OP_ROOT, 8'h00);
        wait_drained();

        // Random names up to the item budget
        while (counted_items < TOTAL_ITEMS) send_name();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over %0d names, %0d wire bytes compared, %0d hold-offs",
                 sb.requests_noted,
                 sb.roots_by_err[0] + sb.roots_by_err[1] + sb.roots_by_err[2]
                     + sb.roots_by_err[3],
                 sb.bytes_checked, hold_off_count);
        $display("Names ending ok/label too long/name too long/empty label: %0d/%0d/%0d/%0d",
                 sb.roots_by_err[dnle_pkg::ERR_OK], sb.roots_by_err[dnle_pkg::ERR_LABEL_LONG],
                 sb.roots_by_err[dnle_pkg::ERR_NAME_LONG], sb.roots_by_err[dnle_pkg::ERR_EMPTY]);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d response bytes outstanding", sb.pending());
        $display("Some tests failed");
        $finish;
    end

endmodule
